/* hdl/ibdc_pkg.sv */
// ----------------------------------------------------------------------------
// ibdc_pkg
// Shared types and constants for the IMU bias and deadband calibrator.
// ----------------------------------------------------------------------------
package ibdc_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int NUM_AXES        = 3;
  localparam int AXIS_W          = 2;
  localparam int CFG_COUNT_W     = 16;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int FIFO_DEPTH      = 4;

  localparam logic [CFG_COUNT_W-1:0] COUNT_RESET = 16'd1000;

  localparam logic [CFG_INDEX_W-1:0] REG_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_X = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_Y = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_Z = 2'd3;

  localparam logic [AXIS_W-1:0] LAST_AXIS = 2'd2;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_ACCUM,
    OP_ACCUM_LAST,
    OP_BAND,
    OP_HOLD,
    OP_CORRECT
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [CFG_COUNT_W-1:0] count;
  } ctrl_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LAUNCH,
    BK_WAIT
  } back_state_t;

endpackage

/* hdl/ibdc_front.sv */
// ----------------------------------------------------------------------------
// ibdc_front
// Holds the configuration registers and the calibration sequence counter,
// applies axis inversion and tags each sample with the operation it needs.
// ----------------------------------------------------------------------------
module ibdc_front import ibdc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [CFG_INDEX_W-1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [NUM_AXES*SAMPLE_BITS-1:0]   in_samples,
  input  logic                              in_restart,
  output logic                              push,
  input  logic                              push_ready,
  output ctrl_t                             push_ctrl,
  output logic [NUM_AXES*SAMPLE_BITS-1:0]   push_samples
);

  localparam int CMP_W = ((COUNT_BITS > CFG_COUNT_W) ? COUNT_BITS : CFG_COUNT_W) + 2;
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  logic [CFG_COUNT_W-1:0] count;
  logic [NUM_AXES-1:0]    invert;
  logic [COUNT_BITS-1:0]  cnt;
  logic                   done;
  logic [COUNT_BITS-1:0]  cnt_eff;
  logic                   done_eff;
  logic [COUNT_BITS-1:0]  cnt_next;
  logic                   done_next;
  logic [CMP_W-1:0]       cnt_x;
  logic [CMP_W-1:0]       n_x;
  logic [CMP_W-1:0]       twice;
  logic [CMP_W-1:0]       twice_next;
  op_t                    op;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= COUNT_RESET;
      invert <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COUNT:    count     <= cfg_data[CFG_COUNT_W-1:0];
        REG_INVERT_X: invert[0] <= cfg_data[0];
        REG_INVERT_Y: invert[1] <= cfg_data[0];
        REG_INVERT_Z: invert[2] <= cfg_data[0];
      endcase
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    logic signed [SAMPLE_BITS-1:0] raw;
    assign raw = in_samples[a*SAMPLE_BITS +: SAMPLE_BITS];
    always_comb begin
      if (!invert[a]) begin
        push_samples[a*SAMPLE_BITS +: SAMPLE_BITS] = raw;
      end else if (raw == S_MIN) begin
        push_samples[a*SAMPLE_BITS +: SAMPLE_BITS] = S_MAX;
      end else begin
        push_samples[a*SAMPLE_BITS +: SAMPLE_BITS] = -raw;
      end
    end
  end

  always_comb begin
    cnt_eff    = in_restart ? '0 : cnt;
    done_eff   = in_restart ? 1'b0 : done;
    cnt_x      = CMP_W'(cnt_eff);
    n_x        = CMP_W'(count);
    twice      = cnt_x << 1;
    twice_next = (cnt_x + CMP_W'(1)) << 1;
    priority if (done_eff) begin
      op = OP_CORRECT;
    end else if (cnt_eff == '0) begin
      op = OP_CLEAR;
    end else if (twice <= n_x) begin
      op = (twice_next > n_x) ? OP_ACCUM_LAST : OP_ACCUM;
    end else if (cnt_x <= n_x) begin
      op = OP_BAND;
    end else begin
      op = OP_HOLD;
    end
    if (done_eff) begin
      cnt_next  = cnt_eff;
      done_next = 1'b1;
    end else if (cnt_x >= n_x) begin
      cnt_next  = '0;
      done_next = 1'b1;
    end else begin
      cnt_next  = cnt_eff + COUNT_BITS'(1);
      done_next = 1'b0;
    end
  end

  assign in_ready        = push_ready;
  assign push            = in_valid && push_ready;
  assign push_ctrl.op    = op;
  assign push_ctrl.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (push) begin
      cnt  <= cnt_next;
      done <= done_next;
    end
  end

endmodule

/* hdl/ibdc_fifo.sv */
// ----------------------------------------------------------------------------
// ibdc_fifo
// Small queue between the classifying front end and the processing back end.
// ----------------------------------------------------------------------------
module ibdc_fifo import ibdc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] level;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (level != CNT_W'(DEPTH));
  assign rd_valid = (level != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        level <= level + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        level <= level - CNT_W'(1);
      end
    end
  end

endmodule

/* hdl/ibdc_div.sv */
// ----------------------------------------------------------------------------
// ibdc_div
// Restoring divider, one quotient bit per cycle, for the rounded offset.
// ----------------------------------------------------------------------------
module ibdc_div import ibdc_pkg::*; #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 17,
  parameter int Q_W   = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quotient
);

  localparam int STEP_W = $clog2(Q_W + 1);

  logic [DEN_W-1:0]  rem;
  logic [Q_W-1:0]    low;
  logic [DEN_W-1:0]  divisor;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  // The quotient is known to fit in Q_W bits, so the upper numerator part
  // is already below the divisor and only Q_W steps are needed.
  always_comb begin
    trial = {rem, low[Q_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
  end

  assign quotient = low;

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= num[Q_W +: DEN_W];
      low     <= num[Q_W-1:0];
      divisor <= den;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low <= {low[Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(Q_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/ibdc_back.sv */
// ----------------------------------------------------------------------------
// ibdc_back
// Executes queued operations: offset sums, offset division, deadband limits
// and the corrected output, held in an output register.
// ----------------------------------------------------------------------------
module ibdc_back import ibdc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  output logic                                q_ready,
  input  ctrl_t                               q_ctrl,
  input  logic [NUM_AXES*SAMPLE_BITS-1:0]     q_samples,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [NUM_AXES*(SAMPLE_BITS+1)-1:0] out_samples,
  output logic                                out_cal
);

  localparam int SUM_W = SAMPLE_BITS + CFG_COUNT_W;
  localparam int NUM_W = SUM_W + 2;
  localparam int DEN_W = CFG_COUNT_W + 1;
  localparam int Q_W   = SAMPLE_BITS + 1;
  localparam int OUT_W = SAMPLE_BITS + 1;

  back_state_t state;
  back_state_t state_next;

  logic                          pop;
  logic                          push_now;
  logic                          div_start;
  logic                          div_done;
  logic [Q_W-1:0]                div_q;
  logic [NUM_W-1:0]              div_num;
  logic [DEN_W-1:0]              div_den;
  logic [AXIS_W-1:0]             axis;
  logic [CFG_COUNT_W-1:0]        div_count;
  logic signed [SUM_W-1:0]       sel_sum;
  logic [SUM_W-1:0]              sel_mag;
  logic [Q_W-1:0]                signed_q;

  logic signed [SUM_W-1:0]       sum    [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] offset [NUM_AXES];
  logic signed [OUT_W-1:0]       bmin   [NUM_AXES];
  logic signed [OUT_W-1:0]       bmax   [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] s      [NUM_AXES];
  logic signed [OUT_W-1:0]       d      [NUM_AXES];
  logic signed [OUT_W-1:0]       res    [NUM_AXES];

  assign pop     = (state == BK_IDLE) && q_valid && (!out_valid || out_ready);
  assign q_ready = pop;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    assign s[a] = q_samples[a*SAMPLE_BITS +: SAMPLE_BITS];
    assign d[a] = OUT_W'(s[a]) - OUT_W'(offset[a]);
    assign res[a] = (d[a] >= bmin[a] && d[a] <= bmax[a]) ? '0 : d[a];

    always_ff @(posedge clk) begin
      if (pop) begin
        unique case (q_ctrl.op)
          OP_CLEAR: begin
            sum[a]    <= '0;
            offset[a] <= '0;
            bmin[a]   <= '0;
            bmax[a]   <= '0;
          end
          OP_ACCUM, OP_ACCUM_LAST: begin
            sum[a] <= sum[a] + SUM_W'(s[a]);
          end
          OP_BAND: begin
            if (d[a] > bmax[a]) begin
              bmax[a] <= d[a];
            end
            if (d[a] < bmin[a]) begin
              bmin[a] <= d[a];
            end
          end
          default: begin
          end
        endcase
      end else if (state == BK_WAIT && div_done && axis == AXIS_W'(a)) begin
        offset[a] <= signed_q[SAMPLE_BITS-1:0];
      end
    end
  end

  always_comb begin
    sel_sum  = sum[axis];
    sel_mag  = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
    div_num  = {sel_mag, 2'b00} + NUM_W'(div_count);
    div_den  = {div_count, 1'b0};
    signed_q = sel_sum[SUM_W-1] ? -div_q : div_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    push_now   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (pop) begin
          if (q_ctrl.op == OP_ACCUM_LAST) begin
            state_next = BK_LAUNCH;
          end else begin
            push_now = 1'b1;
          end
        end
      end
      BK_LAUNCH: begin
        div_start  = 1'b1;
        state_next = BK_WAIT;
      end
      BK_WAIT: begin
        if (div_done) begin
          if (axis == LAST_AXIS) begin
            state_next = BK_IDLE;
            push_now   = 1'b1;
          end else begin
            state_next = BK_LAUNCH;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      axis      <= '0;
      div_count <= q_ctrl.count;
    end else if (state == BK_WAIT && div_done) begin
      axis <= axis + AXIS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_now) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_now) begin
      out_cal <= (state == BK_IDLE) && (q_ctrl.op == OP_CORRECT);
      for (int a = 0; a < NUM_AXES; a++) begin
        if (state == BK_IDLE && q_ctrl.op == OP_CORRECT) begin
          out_samples[a*OUT_W +: OUT_W] <= res[a];
        end else begin
          out_samples[a*OUT_W +: OUT_W] <= '0;
        end
      end
    end
  end

  ibdc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (Q_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

/* hdl/imu_bias_deadband_calibrator_top.sv */
// ----------------------------------------------------------------------------
// imu_bias_deadband_calibrator_top
// Three-axis IMU offset and deadband calibration on a sample stream.
// ----------------------------------------------------------------------------
// Raw samples enter on the s_axis channel, one three-axis sample per beat,
// with tuser set to restart calibration on that beat. Each beat produces
// exactly one beat on m_axis: zeros with tuser low while calibrating, then
// the offset-corrected sample with tuser high, zeroed inside the learned
// deadband. The cfg port writes the sample count and the axis inversions
// and is meant to be used while the stream is idle.
// A beat passes through the queue and then the output register on its way
// to m_axis, and one beat is taken per cycle while the queue is not full.
// The beat that completes the offset sum waits for a shared restoring
// divider, which performs three divisions in turn, one for each axis.
// A four-entry queue lets input keep flowing during that time until full.
// Reset restores the default configuration and starts a new calibration.
// When the receiver stalls, the output beat is held and the queue fills,
// after which s_axis_tready drops.
// ----------------------------------------------------------------------------
module imu_bias_deadband_calibrator_top import ibdc_pkg::*; #(
  parameter  int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter  int COUNT_BITS  = COUNT_BITS_DEF,
  localparam int IN_W        = ((NUM_AXES * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W       = ((NUM_AXES * (SAMPLE_BITS + 1) + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_W-1:0]        s_axis_tdata,  // sample_x, sample_y, sample_z
  input  logic                   s_axis_tuser,  // restart_calibration
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_W-1:0]       m_axis_tdata,  // out_x, out_y, out_z
  output logic                   m_axis_tuser   // calibrated
);

  localparam int SMP_W   = NUM_AXES * SAMPLE_BITS;
  localparam int RES_W   = NUM_AXES * (SAMPLE_BITS + 1);
  localparam int ENTRY_W = $bits(ctrl_t) + SMP_W;

  logic               push;
  logic               push_ready;
  ctrl_t              push_ctrl;
  logic [SMP_W-1:0]   push_samples;
  logic               q_valid;
  logic               q_ready;
  logic [ENTRY_W-1:0] q_data;
  ctrl_t              q_ctrl;
  logic [SMP_W-1:0]   q_samples;
  logic [RES_W-1:0]   out_samples;

  ibdc_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_samples   (s_axis_tdata[SMP_W-1:0]),
    .in_restart   (s_axis_tuser),
    .push         (push),
    .push_ready   (push_ready),
    .push_ctrl    (push_ctrl),
    .push_samples (push_samples)
  );

  ibdc_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push),
    .wr_ready (push_ready),
    .wr_data  ({push_ctrl, push_samples}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  assign q_ctrl    = ctrl_t'(q_data[ENTRY_W-1:SMP_W]);
  assign q_samples = q_data[SMP_W-1:0];

  ibdc_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_ctrl      (q_ctrl),
    .q_samples   (q_samples),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_samples (out_samples),
    .out_cal     (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_W'(out_samples);

  a_zero_while_calibrating: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("Nonzero output beat while calibrating.");

  a_no_output_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("Output beat valid right after reset.");

  a_pop_only_when_queued: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> q_valid)
    else $error("Back end took an entry from an empty queue.");

endmodule
